// ===== design/tabump_pkg.sv =====
// ----------------------------------------------------------------------------
// tabump_pkg
// Shared types and constants of the tensor arena bump allocator.
// ----------------------------------------------------------------------------
package tabump_pkg;

  // Arena layout constants
  localparam int unsigned DESCRIPTOR_BYTES = 48;
  localparam int unsigned ALIGN_LOG2       = 4;
  localparam int unsigned ALIGN_BYTES      = 1 << ALIGN_LOG2;
  localparam int unsigned DESC_ALIGNED     =
    ((DESCRIPTOR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned MAX_DIMS         = 4;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFF_W  = 34;   // aligned offsets
  localparam int unsigned END_W  = 35;   // offset plus descriptor plus size

  typedef enum logic [1:0] {
    MODE_SETUP   = 2'd0,
    MODE_TENSOR  = 2'd1,
    MODE_SCRATCH = 2'd2,
    MODE_RESET   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_BAD_ARG   = 2'd2,
    STAT_NO_SPACE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_REGION_BASE   = 2'd0,
    CFG_REGION_TOTAL  = 2'd1,
    CFG_SCRATCH_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PLACE,
    ST_EXEC,
    ST_STAT,
    ST_OUT
  } state_t;

  // Control into the shared size multiplier
  typedef struct packed {
    logic              start;
    logic              step;
    logic [WORD_W-1:0] operand;
  } size_ctl_t;

  // Running size product
  typedef struct packed {
    logic              over;
    logic [WORD_W-1:0] value;
  } size_res_t;

  function automatic logic [2:0] elem_bytes(input logic [2:0] etype);
    logic [2:0] eb;
    unique case (etype)
      3'd2, 3'd3: eb = 3'd2;
      3'd4:       eb = 3'd4;
      default:    eb = 3'd1;
    endcase
    return eb;
  endfunction

endpackage

// ===== design/tabump_size_unit.sv =====
// ----------------------------------------------------------------------------
// tabump_size_unit
// Shared 32x32 multiplier that accumulates the tensor size one factor a cycle.
// ----------------------------------------------------------------------------
module tabump_size_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tabump_pkg::size_ctl_t ctl,
  output tabump_pkg::size_res_t res
);
  import tabump_pkg::*;

  logic [WORD_W-1:0]   prod_r, prod_nxt;
  logic                zero_r, zero_nxt;
  logic                ovf_r, ovf_nxt;
  logic [2*WORD_W-1:0] mul;

  assign mul = prod_r * ctl.operand;

  always_comb begin
    prod_nxt = prod_r;
    zero_nxt = zero_r;
    ovf_nxt  = ovf_r;
    if (ctl.start) begin
      prod_nxt = WORD_W'(1);
      zero_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end else if (ctl.step) begin
      prod_nxt = mul[WORD_W-1:0];
      // a zero extent wins over any overflow
      zero_nxt = zero_r | (ctl.operand == '0);
      ovf_nxt  = ovf_r | (mul[2*WORD_W-1:WORD_W] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      zero_r <= zero_nxt;
      ovf_r  <= ovf_nxt;
    end
    prod_r <= prod_nxt;
  end

  assign res.over  = ovf_r & ~zero_r;
  assign res.value = zero_r ? '0 : prod_r;

endmodule

// ===== design/tensor_arena_bump_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tensor_arena_bump_allocator_core
// Bump allocator over one arena: persistent, ephemeral and scratch regions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per transaction; in_mode selects set-up,
//   tensor allocate, scratch acquire or ephemeral reset.
//   Output channel (out_*): exactly one result transaction per request, with
//   status, addresses and the running statistics.
//   Config port (cfg_*): cfg_we writes cfg_wdata to register cfg_index
//   (0 region_base, 1 region_total, 2 scratch_bytes) with no wait state.
//   Registers are sampled only by a set-up request.
// Sequencing:
//   One request at a time. A request passes ST_PLACE, ST_EXEC, ST_STAT and
//   ST_OUT; a tensor request with a valid dimension count on a set-up allocator
//   first runs ST_MUL, one step per dimension plus one for the element size.
//   in_ready returns with the result. The tensor size is built one factor per
//   cycle on a single shared 32x32 multiplier.
// Reset: synchronous rst_n clears the allocator (not set up), the result
//   register and the statistics.
// Stall: a finished result waits in the output register while the next
//   request is already being worked on; that request then waits in its last
//   step until the register frees. in_ready is high only when idle.
// ----------------------------------------------------------------------------
module tensor_arena_bump_allocator_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_dim_count,
  input  logic [31:0] in_dim0,
  input  logic [31:0] in_dim1,
  input  logic [31:0] in_dim2,
  input  logic [31:0] in_dim3,
  input  logic [2:0]  in_element_type,
  input  logic        in_persistent_flag,
  input  logic [31:0] in_request_bytes,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [31:0] out_data_address,
  output logic [31:0] out_data_bytes,
  output logic [31:0] out_used_bytes,
  output logic [31:0] out_peak_bytes,
  output logic [31:0] out_scratch_fill,
  output logic [31:0] out_allocations,
  output logic [31:0] out_resets
);
  import tabump_pkg::*;

  localparam logic [2:0]       MAX_DIMS_C = 3'(MAX_DIMS);
  localparam logic [END_W-1:0] DESC_OFF   = END_W'(DESC_ALIGNED);
  localparam logic [OFF_W-1:0] ALIGN_ADD  = OFF_W'(ALIGN_BYTES - 1);
  localparam logic [OFF_W-1:0] ALIGN_MASK = ~OFF_W'(ALIGN_BYTES - 1);

  // Config registers
  logic [WORD_W-1:0] cfg_base_r, cfg_total_r, cfg_scratch_r;

  // Latched request
  mode_t             mode_r;
  logic [2:0]        ndim_r;
  logic [WORD_W-1:0] dim_r [MAX_DIMS];
  logic [2:0]        etype_r;
  logic              pers_r;
  logic [WORD_W-1:0] req_r;

  // Allocator state
  logic              ready_r;
  logic [WORD_W-1:0] base_l_r, scratch_base_r, scratch_size_r;
  logic [WORD_W-1:0] tspace_r, ptop_r, elen_r, peak_r, used_r;
  logic [WORD_W-1:0] stop_r, alloc_r, resets_r;

  // Work registers
  logic [2:0]        mul_idx_r;
  logic [OFF_W-1:0]  aoff_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] res_blk_r, res_dat_r, res_bytes_r;

  // Output register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [WORD_W-1:0] out_blk_r, out_dat_r, out_bytes_r, out_used_r, out_peak_r;
  logic [WORD_W-1:0] out_fill_r, out_alloc_r, out_resets_r;

  state_t    state_r, state_nxt;
  size_ctl_t size_ctl;
  size_res_t size_res;

  logic in_fire, tensor_ok, mul_last, out_free, out_load;

  assign in_fire   = in_valid & in_ready;
  assign tensor_ok = ready_r && (mode_t'(in_mode) == MODE_TENSOR) &&
                     (in_dim_count != 3'd0) && (in_dim_count <= MAX_DIMS_C);
  assign mul_last  = (mul_idx_r == ndim_r);
  assign out_free  = ~out_valid_r | out_ready;

  tabump_size_unit u_size (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (size_ctl),
    .res   (size_res)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = tensor_ok ? ST_MUL : ST_PLACE;
      ST_MUL:   if (mul_last) state_nxt = ST_PLACE;
      ST_PLACE: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_STAT;
      ST_STAT:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    out_load         = (state_r == ST_OUT) & out_free;
    size_ctl.start   = in_fire & tensor_ok;
    size_ctl.step    = (state_r == ST_MUL);
    // dimensions first, element size as the last factor
    size_ctl.operand = mul_last ? WORD_W'(elem_bytes(etype_r)) : dim_r[mul_idx_r[1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r    <= '0;
      cfg_total_r   <= '0;
      cfg_scratch_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REGION_BASE:   cfg_base_r    <= cfg_wdata;
        CFG_REGION_TOTAL:  cfg_total_r   <= cfg_wdata;
        CFG_SCRATCH_BYTES: cfg_scratch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request capture and factor counter
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= mode_t'(in_mode);
      ndim_r   <= in_dim_count;
      dim_r[0] <= in_dim0;
      dim_r[1] <= in_dim1;
      dim_r[2] <= in_dim2;
      dim_r[3] <= in_dim3;
      etype_r  <= in_element_type;
      pers_r   <= in_persistent_flag;
      req_r    <= in_request_bytes;
    end
    if (in_fire)                mul_idx_r <= '0;
    else if (state_r == ST_MUL) mul_idx_r <= mul_idx_r + 3'd1;
  end

  // --------------------------------------------------------------------------
  // Placement: aligned start offset of the region or scratch pool top
  // --------------------------------------------------------------------------
  logic [WORD_W:0] place_off;

  always_comb begin
    if (mode_r == MODE_SCRATCH) place_off = {1'b0, stop_r};
    else if (pers_r)            place_off = {1'b0, ptop_r};
    else                        place_off = {1'b0, ptop_r} + {1'b0, elen_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PLACE) begin
      aoff_r <= (OFF_W'(place_off) + ALIGN_ADD) & ALIGN_MASK;
    end
  end

  // --------------------------------------------------------------------------
  // Execute: decision, state update and result
  // --------------------------------------------------------------------------
  logic [END_W-1:0]  t_end, s_end;
  logic              setup_bad, ndim_bad, tensor_fits, scratch_fits;
  logic [WORD_W:0]   used_sum;
  status_t           res_status_nxt;
  logic [WORD_W-1:0] res_blk_nxt, res_dat_nxt, res_bytes_nxt;

  assign t_end        = END_W'(aoff_r) + DESC_OFF + END_W'(size_res.value);
  assign s_end        = END_W'(aoff_r) + END_W'(req_r);
  assign setup_bad    = (cfg_base_r == '0) || (cfg_total_r == '0) ||
                        (cfg_total_r <= cfg_scratch_r);
  assign ndim_bad     = (ndim_r == 3'd0) || (ndim_r > MAX_DIMS_C);
  assign tensor_fits  = !size_res.over && (t_end <= END_W'(tspace_r));
  assign scratch_fits = (s_end <= END_W'(scratch_size_r));
  assign used_sum     = {1'b0, ptop_r} + {1'b0, elen_r};

  // result of the request in flight; status OK means the state advances
  always_comb begin
    res_status_nxt = STAT_OK;
    res_blk_nxt    = '0;
    res_dat_nxt    = '0;
    res_bytes_nxt  = '0;
    priority if (mode_r == MODE_SETUP) begin
      if (setup_bad) res_status_nxt = STAT_BAD_ARG;
    end else if (!ready_r) begin
      res_status_nxt = STAT_NOT_READY;
    end else if (mode_r == MODE_TENSOR) begin
      if (ndim_bad) begin
        res_status_nxt = STAT_BAD_ARG;
      end else if (!tensor_fits) begin
        res_status_nxt = STAT_NO_SPACE;
      end else begin
        res_blk_nxt   = base_l_r + aoff_r[WORD_W-1:0];
        res_dat_nxt   = res_blk_nxt + WORD_W'(DESC_ALIGNED);
        res_bytes_nxt = size_res.value;
      end
    end else if (mode_r == MODE_SCRATCH) begin
      if (req_r == '0) begin
        res_status_nxt = STAT_BAD_ARG;
      end else if (!scratch_fits) begin
        res_status_nxt = STAT_NO_SPACE;
      end else begin
        res_blk_nxt   = scratch_base_r + aoff_r[WORD_W-1:0];
        res_dat_nxt   = res_blk_nxt;
        res_bytes_nxt = req_r;
      end
    end else begin
      // ephemeral reset hands out no block
      res_status_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r        <= 1'b0;
      base_l_r       <= '0;
      scratch_base_r <= '0;
      scratch_size_r <= '0;
      tspace_r       <= '0;
      ptop_r         <= '0;
      elen_r         <= '0;
      peak_r         <= '0;
      used_r         <= '0;
      stop_r         <= '0;
      alloc_r        <= '0;
      resets_r       <= '0;
    end else if (state_r == ST_EXEC) begin
      res_status_r <= res_status_nxt;
      res_blk_r    <= res_blk_nxt;
      res_dat_r    <= res_dat_nxt;
      res_bytes_r  <= res_bytes_nxt;
      if (res_status_nxt == STAT_OK) begin
        unique case (mode_r)
          MODE_SETUP: begin
            ready_r        <= 1'b1;
            base_l_r       <= cfg_base_r;
            scratch_size_r <= cfg_scratch_r;
            tspace_r       <= cfg_total_r - cfg_scratch_r;
            scratch_base_r <= cfg_base_r + (cfg_total_r - cfg_scratch_r);
            ptop_r         <= '0;
            elen_r         <= '0;
            peak_r         <= '0;
            used_r         <= '0;
            stop_r         <= '0;
            alloc_r        <= '0;
            resets_r       <= '0;
          end
          MODE_TENSOR: begin
            if (pers_r) ptop_r <= t_end[WORD_W-1:0];
            else        elen_r <= t_end[WORD_W-1:0] - ptop_r;
            alloc_r <= alloc_r + 32'd1;
          end
          MODE_SCRATCH: begin
            stop_r  <= s_end[WORD_W-1:0];
            alloc_r <= alloc_r + 32'd1;
          end
          MODE_RESET: begin
            // ephemeral reset also empties the scratch pool
            elen_r   <= '0;
            stop_r   <= '0;
            resets_r <= resets_r + 32'd1;
          end
        endcase
      end
    end else if (state_r == ST_STAT) begin
      // saturating used sum; peak tracks its maximum
      if (used_sum[WORD_W]) begin
        used_r <= '1;
        peak_r <= '1;
      end else begin
        used_r <= used_sum[WORD_W-1:0];
        if (used_sum[WORD_W-1:0] > peak_r) peak_r <= used_sum[WORD_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_dat_r    <= res_dat_r;
      out_bytes_r  <= res_bytes_r;
      out_used_r   <= used_r;
      out_peak_r   <= peak_r;
      out_fill_r   <= stop_r;
      out_alloc_r  <= alloc_r;
      out_resets_r <= resets_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_blk_r;
  assign out_data_address  = out_dat_r;
  assign out_data_bytes    = out_bytes_r;
  assign out_used_bytes    = out_used_r;
  assign out_peak_bytes    = out_peak_r;
  assign out_scratch_fill  = out_fill_r;
  assign out_allocations   = out_alloc_r;
  assign out_resets        = out_resets_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= used_r)
    else $error("peak below current use");

  a_ptop_in_space: assert property (@(posedge clk) disable iff (!rst_n)
    ptop_r <= tspace_r)
    else $error("persistent top beyond tensor space");

  a_scratch_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r <= scratch_size_r)
    else $error("scratch fill beyond pool size");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown without a finished request");

endmodule

// ===== test/tensor_arena_bump_allocator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_arena_bump_allocator_core_test
// Self-checking bench for the arena bump allocator. A scoreboard keeps its own
// copy of the allocator state, predicts one grant per accepted request and
// compares every result transaction field by field. Stimulus is a directed
// sweep of corner cases followed by randomized phases over several arena
// layouts, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tensor_arena_bump_allocator_core_test;
  import tabump_pkg::*;

  typedef struct packed {
    mode_t            mode;
    logic [2:0]       dim_count;
    logic [3:0][31:0] dim;
    logic [2:0]       element_type;
    logic             persistent;
    logic [31:0]      request_bytes;
  } alloc_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [31:0] data_address;
    logic [31:0] data_bytes;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;
    logic [31:0] scratch_fill;
    logic [31:0] allocations;
    logic [31:0] resets;
  } alloc_result_t;

  class grant_scoreboard;
    bit [31:0] reg_base, reg_total, reg_scratch;
    bit        armed;
    bit [31:0] tensor_space, pers_top, eph_len, peak_used;
    bit [31:0] scratch_top, alloc_cnt, reset_cnt, base_l, pool_l;
    alloc_result_t pending_grants[$];
    int errors;

    function void write_reg(cfg_idx_t idx, bit [31:0] v);
      case (idx)
        CFG_REGION_BASE:   reg_base = v;
        CFG_REGION_TOTAL:  reg_total = v;
        CFG_SCRATCH_BYTES: reg_scratch = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    function bit [34:0] round_to_grain(bit [34:0] x);
      return ((x + 35'(ALIGN_BYTES) - 35'd1) / 35'(ALIGN_BYTES)) * 35'(ALIGN_BYTES);
    endfunction

    function bit [31:0] used_total();
      bit [32:0] sum;
      sum = {1'b0, pers_top} + {1'b0, eph_len};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Predicts the grant for one accepted request and queues it
    function void note_request(alloc_request_t r);
      alloc_result_t want;
      bit [63:0] size;
      bit        zero_dim;
      bit [34:0] desc_span, off, aoff, fin;
      bit [31:0] blk;
      int        i;
      want = '0;
      want.status = STAT_OK;
      desc_span = round_to_grain(35'(DESCRIPTOR_BYTES));
      if (r.mode == MODE_SETUP) begin
        if (reg_base == 0 || reg_total == 0 || reg_total <= reg_scratch) begin
          want.status = STAT_BAD_ARG;
        end else begin
          armed = 1'b1;
          base_l = reg_base;
          pool_l = reg_scratch;
          tensor_space = reg_total - reg_scratch;
          pers_top = 0; eph_len = 0; peak_used = 0;
          scratch_top = 0; alloc_cnt = 0; reset_cnt = 0;
        end
      end else if (!armed) begin
        want.status = STAT_NOT_READY;
      end else if (r.mode == MODE_TENSOR) begin
        if (r.dim_count == 0 || r.dim_count > MAX_DIMS) begin
          want.status = STAT_BAD_ARG;
        end else begin
          size = 64'd1;
          zero_dim = 1'b0;
          for (i = 0; i < int'(r.dim_count); i++) begin
            if (r.dim[i] == 0) zero_dim = 1'b1;
            size = size * 64'(r.dim[i]);
            // pin at 2^32 so the product stays flagged as too big
            if (size > 64'hFFFF_FFFF) size = 64'h1_0000_0000;
          end
          if (zero_dim) size = 0;
          case (r.element_type)
            3'd2, 3'd3: size = size * 64'd2;
            3'd4:       size = size * 64'd4;
            default: ;
          endcase
          if (size > 64'hFFFF_FFFF) begin
            want.status = STAT_NO_SPACE;
          end else begin
            off = r.persistent ? 35'(pers_top) : 35'(pers_top) + 35'(eph_len);
            aoff = round_to_grain(off);
            fin = aoff + desc_span + 35'(size[31:0]);
            if (fin > 35'(tensor_space)) begin
              want.status = STAT_NO_SPACE;
            end else begin
              if (r.persistent) pers_top = fin[31:0];
              else eph_len = fin[31:0] - pers_top;
              if (used_total() > peak_used) peak_used = used_total();
              alloc_cnt++;
              blk = base_l + aoff[31:0];
              want.block_address = blk;
              want.data_address = blk + desc_span[31:0];
              want.data_bytes = size[31:0];
            end
          end
        end
      end else if (r.mode == MODE_SCRATCH) begin
        if (r.request_bytes == 0) begin
          want.status = STAT_BAD_ARG;
        end else begin
          aoff = round_to_grain(35'(scratch_top));
          fin = aoff + 35'(r.request_bytes);
          if (fin > 35'(pool_l)) begin
            want.status = STAT_NO_SPACE;
          end else begin
            scratch_top = fin[31:0];
            alloc_cnt++;
            blk = base_l + tensor_space + aoff[31:0];
            want.block_address = blk;
            want.data_address = blk;
            want.data_bytes = r.request_bytes;
          end
        end
      end else begin
        eph_len = 0;
        scratch_top = 0;
        reset_cnt++;
      end
      want.used_bytes = used_total();
      want.peak_bytes = peak_used;
      want.scratch_fill = scratch_top;
      want.allocations = alloc_cnt;
      want.resets = reset_cnt;
      pending_grants.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_grant(alloc_result_t got);
      alloc_result_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("block_address", want.block_address, got.block_address);
      compare_field("data_address", want.data_address, got.data_address);
      compare_field("data_bytes", want.data_bytes, got.data_bytes);
      compare_field("used_bytes", want.used_bytes, got.used_bytes);
      compare_field("peak_bytes", want.peak_bytes, got.peak_bytes);
      compare_field("scratch_fill", want.scratch_fill, got.scratch_fill);
      compare_field("allocations", want.allocations, got.allocations);
      compare_field("resets", want.resets, got.resets);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [2:0]  in_dim_count;
  logic [31:0] in_dim0, in_dim1, in_dim2, in_dim3;
  logic [2:0]  in_element_type;
  logic        in_persistent_flag;
  logic [31:0] in_request_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_block_address, out_data_address, out_data_bytes;
  logic [31:0] out_used_bytes, out_peak_bytes, out_scratch_fill;
  logic [31:0] out_allocations, out_resets;

  grant_scoreboard arena;

  // burst: both sides stop idling; hold_request: ask the sink for one long stall
  bit burst;
  bit hold_request;

  tensor_arena_bump_allocator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_dim_count       (in_dim_count),
    .in_dim0            (in_dim0),
    .in_dim1            (in_dim1),
    .in_dim2            (in_dim2),
    .in_dim3            (in_dim3),
    .in_element_type    (in_element_type),
    .in_persistent_flag (in_persistent_flag),
    .in_request_bytes   (in_request_bytes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_block_address  (out_block_address),
    .out_data_address   (out_data_address),
    .out_data_bytes     (out_data_bytes),
    .out_used_bytes     (out_used_bytes),
    .out_peak_bytes     (out_peak_bytes),
    .out_scratch_fill   (out_scratch_fill),
    .out_allocations    (out_allocations),
    .out_resets         (out_resets)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Offer one request; returns at the edge where the transaction is taken.
  // Drive changes happen at negedge only, one assignment per signal per step.
  task automatic send_request(input alloc_request_t r);
    @(negedge clk);
    while (!burst && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= r.mode;
    in_dim_count       <= r.dim_count;
    in_dim0            <= r.dim[0];
    in_dim1            <= r.dim[1];
    in_dim2            <= r.dim[2];
    in_dim3            <= r.dim[3];
    in_element_type    <= r.element_type;
    in_persistent_flag <= r.persistent;
    in_request_bytes   <= r.request_bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    arena.note_request(r);
  endtask

  // Registers only change with the allocator drained: input dropped, no
  // grants outstanding, plus a margin covering the longest tensor latency.
  task automatic configure(input bit [31:0] base, input bit [31:0] total,
                           input bit [31:0] pool);
    @(negedge clk);
    in_valid <= 1'b0;
    while (arena.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_REGION_BASE; cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_REGION_TOTAL; cfg_wdata <= total;
    @(negedge clk);
    cfg_index <= CFG_SCRATCH_BYTES; cfg_wdata <= pool;
    @(negedge clk);
    cfg_we <= 1'b0;
    arena.write_reg(CFG_REGION_BASE, base);
    arena.write_reg(CFG_REGION_TOTAL, total);
    arena.write_reg(CFG_SCRATCH_BYTES, pool);
  endtask

  function automatic alloc_request_t make_request(
      mode_t m, bit [2:0] cnt, bit [31:0] d0, bit [31:0] d1, bit [31:0] d2,
      bit [31:0] d3, bit [2:0] et, bit pf, bit [31:0] rb);
    alloc_request_t r;
    r.mode = m;
    r.dim_count = cnt;
    r.dim = {d3, d2, d1, d0};
    r.element_type = et;
    r.persistent = pf;
    r.request_bytes = rb;
    return r;
  endfunction

  // Mostly well-formed allocation traffic with small extents so the arena
  // fills and recycles; a share of zero, wide and out-of-range values mixed in.
  function automatic alloc_request_t random_request();
    alloc_request_t r;
    int pick, roll, i;
    pick = $urandom_range(0, 99);
    if (pick < 3) r.mode = MODE_SETUP;
    else if (pick < 12) r.mode = MODE_RESET;
    else if (pick < 42) r.mode = MODE_SCRATCH;
    else r.mode = MODE_TENSOR;
    if ($urandom_range(0, 99) < 85) r.dim_count = 3'($urandom_range(1, MAX_DIMS));
    else r.dim_count = 3'($urandom_range(0, 7));
    for (i = 0; i < 4; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) r.dim[i] = $urandom_range(1, 16);
      else if (roll < 78) r.dim[i] = 0;
      else if (roll < 88) r.dim[i] = $urandom_range(1, 4096);
      else r.dim[i] = $urandom;
    end
    r.element_type = 3'($urandom_range(0, 7));
    r.persistent = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 60) r.request_bytes = $urandom_range(1, 64);
    else if (roll < 70) r.request_bytes = 0;
    else if (roll < 85) r.request_bytes = $urandom_range(1, 4096);
    else r.request_bytes = $urandom;
    return r;
  endfunction

  // Result sink: random back-pressure, one long stall on request.
  initial begin : result_sink
    int hold_left;
    alloc_result_t got;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= burst || ($urandom_range(0, 99) >= 38);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.status        = out_status;
        got.block_address = out_block_address;
        got.data_address  = out_data_address;
        got.data_bytes    = out_data_bytes;
        got.used_bytes    = out_used_bytes;
        got.peak_bytes    = out_peak_bytes;
        got.scratch_fill  = out_scratch_fill;
        got.allocations   = out_allocations;
        got.resets        = out_resets;
        arena.check_grant(got);
      end
    end
  end

  initial begin : stimulus
    int p, n;
    bit [31:0] b, t, s;
    arena = new();
    burst = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REGION_BASE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_SETUP;
    in_dim_count = '0;
    in_dim0 = '0; in_dim1 = '0; in_dim2 = '0; in_dim3 = '0;
    in_element_type = '0;
    in_persistent_flag = 1'b0;
    in_request_bytes = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Before any set-up: every request reports not set up; set-up with
    // cleared registers is rejected (zero base).
    send_request(make_request(MODE_TENSOR, 1, 5, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 8));
    send_request(make_request(MODE_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));

    // Pool as large as the arena: set-up rejected
    configure(32'h1000, 32'h1000, 32'h1000);
    send_request(make_request(MODE_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));

    // 3 KiB tensor space, 1 KiB scratch pool
    configure(32'h1000, 32'h1000, 32'h400);
    send_request(make_request(MODE_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 0, 1, 1, 1, 1, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 5, 1, 1, 1, 1, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 7, 1, 1, 1, 1, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 1, 3, 0, 0, 0, 0, 0, 0));
    // persistent block lands under the ephemeral one (overlap)
    send_request(make_request(MODE_TENSOR, 2, 2, 3, 0, 0, 3, 1, 0));
    send_request(make_request(MODE_TENSOR, 4, 2, 2, 2, 2, 4, 0, 0));
    // zero extent wins over huge extents
    send_request(make_request(MODE_TENSOR, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 4, 0, 0));
    send_request(make_request(MODE_TENSOR, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 4, 0, 0));
    // product exactly 2^32 after the element width
    send_request(make_request(MODE_TENSOR, 1, 32'h4000_0000, 0, 0, 0, 4, 1, 0));
    send_request(make_request(MODE_TENSOR, 1, 4000, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 1, 1, 0, 0, 0, 7, 0, 0));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 1));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 17));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 32'h400));
    send_request(make_request(MODE_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
    // exactly fills the pool
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 32'h400));

    // Top of the address space: addresses wrap, used sum saturates, no pool
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0);
    send_request(make_request(MODE_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 1, 32'hC000_0000, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_TENSOR, 1, 32'hC000_0000, 0, 0, 0, 1, 1, 0));
    send_request(make_request(MODE_SCRATCH, 0, 0, 0, 0, 0, 0, 0, 1));

    // Random phases over several arena layouts, each opened by a set-up
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin b = 32'h0000_1000; t = 32'h0000_0800; s = 32'h100; end
        1: begin b = 32'hFFFF_FF00; t = 32'h0001_0000; s = 32'h4000; end
        2: begin b = 32'hFFFF_FFFF; t = 32'hFFFF_FFFF; s = 32'h0; end
        3: begin b = 32'h0000_0001; t = 32'hFFFF_FFFF; s = 32'hFFFF_FFFE; end
        default: begin
          t = $urandom_range(64, 1 << 20);
          s = $urandom_range(0, t - 1);
          b = $urandom;
          if (b == 0) b = 32'h100;
        end
      endcase
      configure(b, t, s);
      // second layout runs with no idling on either side
      burst = (p == 1);
      send_request(make_request(MODE_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));
      for (n = 0; n < 160; n++) begin
        // mid-phase, stall the sink long enough to back the block up
        if (p == 0 && n == 40) hold_request = 1'b1;
        send_request(random_request());
      end
      burst = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (arena.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (arena.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tabump_pkg.sv
design/tabump_size_unit.sv
design/tensor_arena_bump_allocator_core.sv
test/tensor_arena_bump_allocator_core_test.sv
